// File: hdl/dmc_pkg.sv
// Shared constants, codes and the direction shuffle for the DFS maze carver.
// No dependencies; the carver and the bench refer to it by scoped names.
package dmc_pkg;

  localparam int GRID_COLS_DEF = 16;
  localparam int GRID_ROWS_DEF = 16;

  // request kinds
  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_STEP    = 1'b1;

  // result events
  localparam logic [1:0] EV_RESTART   = 2'd0;
  localparam logic [1:0] EV_CARVE     = 2'd1;
  localparam logic [1:0] EV_BACKTRACK = 2'd2;
  localparam logic [1:0] EV_IDLE      = 2'd3;

  // carve directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef logic [3:0][1:0] dir_order_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [1:0] direction;
    logic [8:0] stack_depth;
    logic       maze_done;
  } result_t;

  // Fisher-Yates swaps for slots 3, 2, 1; a slot-2 draw of 3 acts as 0
  function automatic dir_order_t shuffle_order(input logic [1:0] d3,
                                               input logic [1:0] d2,
                                               input logic       d1);
    dir_order_t o;
    logic [1:0] p2;
    logic [1:0] p1;
    logic [1:0] t;
    o = {DIR_LEFT, DIR_DOWN, DIR_RIGHT, DIR_UP};
    t = o[3];
    o[3] = o[d3];
    o[d3] = t;
    p2 = (d2 == 2'd3) ? 2'd0 : d2;
    t = o[2];
    o[2] = o[p2];
    o[p2] = t;
    p1 = {1'b0, d1};
    t = o[1];
    o[1] = o[p1];
    o[p1] = t;
    return o;
  endfunction

endpackage

// File: hdl/dmc_ifs.sv
// Valid/ready channel interfaces for carver requests and results.
// Stand-alone; field widths are fixed by the block's request and result formats.
interface dmc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [1:0] draw_three;
  logic [1:0] draw_two;
  logic       draw_one;

  modport source (output valid, req_type, draw_three, draw_two, draw_one, input ready);
  modport sink   (input valid, req_type, draw_three, draw_two, draw_one, output ready);
endinterface

interface dmc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [3:0] cell_x;
  logic [3:0] cell_y;
  logic [1:0] direction;
  logic [8:0] stack_depth;
  logic       maze_done;

  modport source (output valid, event_res, cell_x, cell_y, direction, stack_depth,
                  maze_done, input ready);
  modport sink   (input valid, event_res, cell_x, cell_y, direction, stack_depth,
                  maze_done, output ready);
endinterface

// File: hdl/dmc_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with registered data.
// No dependencies; used for the visited map and the cell stack.
module dmc_ram #(
  parameter int AW = 8,
  parameter int DW = 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/dfs_maze_carver.sv
// Step: stack read, then one visited-map read per in-bounds neighbor tried, up to
// four; a step on an empty stack skips both reads and goes straight to the result.
// Restart: clearing pass over the visited map, 2**(clog2(cols)+clog2(rows)) entries
// (256 at 16x16), then the seed. One request at a time; the result register frees
// the request side while a result waits. Reset runs the same clearing pass and
// accepts no request until it finishes. Depends on dmc_pkg, dmc_ifs, dmc_ram.
module dfs_maze_carver #(
  parameter int GRID_COLS = dmc_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = dmc_pkg::GRID_ROWS_DEF
) (
  input logic      clk,
  input logic      rst,
  dmc_req_if.sink   req,
  dmc_res_if.source res
);

  localparam int XW    = $clog2(GRID_COLS);
  localparam int YW    = $clog2(GRID_ROWS);
  localparam int VW    = XW + YW;
  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int SAW   = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);

  localparam logic [XW-1:0]   X_LAST    = XW'(GRID_COLS - 1);
  localparam logic [YW-1:0]   Y_LAST    = YW'(GRID_ROWS - 1);
  localparam logic [CNTW-1:0] CELLS_CNT = CNTW'(CELLS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_SEED  = 3'd1;
  localparam logic [2:0] ST_IDLE  = 3'd2;
  localparam logic [2:0] ST_TOP   = 3'd3;
  localparam logic [2:0] ST_PROBE = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;
  localparam logic [2:0] ST_POP   = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  logic [2:0]          state;
  logic [CNTW-1:0]     count;
  logic [VW-1:0]       clr_addr;
  logic                report;
  dmc_pkg::dir_order_t order;
  logic [1:0]          k;
  logic [XW-1:0]       cur_x;
  logic [YW-1:0]       cur_y;
  logic [XW-1:0]       cand_x;
  logic [YW-1:0]       cand_y;
  logic [1:0]          cand_dir;
  dmc_pkg::result_t    rslt;
  dmc_pkg::result_t    out_data;
  logic                out_valid;

  logic                accept;
  logic [CNTW-1:0]     count_m1;
  logic [1:0]          pd;
  logic [XW-1:0]       nx;
  logic [YW-1:0]       ny;
  logic                inb;
  logic                carve;

  logic                stk_we;
  logic [SAW-1:0]      stk_waddr;
  logic [VW-1:0]       stk_wdata;
  logic                stk_re;
  logic [VW-1:0]       stk_rdata;

  logic                vis_we;
  logic [VW-1:0]       vis_waddr;
  logic [0:0]          vis_wdata;
  logic                vis_re;
  logic [VW-1:0]       vis_raddr;
  logic [0:0]          vis_rdata;

  function automatic dmc_pkg::result_t make_result(input logic [1:0]      ev,
                                                   input logic [XW-1:0]   x,
                                                   input logic [YW-1:0]   y,
                                                   input logic [1:0]      dir,
                                                   input logic [CNTW-1:0] cnt);
    dmc_pkg::result_t r;
    logic [XW+3:0]   xe;
    logic [YW+3:0]   ye;
    logic [CNTW+8:0] ce;
    xe = {4'b0, x};
    ye = {4'b0, y};
    ce = {9'b0, cnt};
    r.event_res   = ev;
    r.cell_x      = xe[3:0];
    r.cell_y      = ye[3:0];
    r.direction   = dir;
    r.stack_depth = ce[8:0];
    r.maze_done   = (cnt == '0);
    return r;
  endfunction

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign count_m1  = count - CNTW'(1);
  assign carve     = (state == ST_CHECK) && !vis_rdata[0];

  // neighbor under test
  always_comb begin
    pd  = order[k];
    nx  = cur_x;
    ny  = cur_y;
    inb = 1'b0;
    case (pd)
      dmc_pkg::DIR_UP: begin
        inb = (cur_y != '0);
        ny  = cur_y - YW'(1);
      end
      dmc_pkg::DIR_RIGHT: begin
        inb = (cur_x != X_LAST);
        nx  = cur_x + XW'(1);
      end
      dmc_pkg::DIR_DOWN: begin
        inb = (cur_y != Y_LAST);
        ny  = cur_y + YW'(1);
      end
      default: begin
        inb = (cur_x != '0);
        nx  = cur_x - XW'(1);
      end
    endcase
  end

  // stack port: seed entry zero, push on carve, read top on a step
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = count[SAW-1:0];
    stk_wdata = {cand_y, cand_x};
    if (state == ST_SEED) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = '0;
    end else if (carve && (count < CELLS_CNT)) begin
      stk_we = 1'b1;
    end
    stk_re = accept && (req.req_type == dmc_pkg::REQ_STEP) && (count != '0);
  end

  // visited port: clear sweep, seed, mark on carve; probe reads
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = {cand_y, cand_x};
    vis_wdata = 1'b1;
    if (state == ST_CLEAR) begin
      vis_we    = 1'b1;
      vis_waddr = clr_addr;
      vis_wdata = 1'b0;
    end else if (state == ST_SEED) begin
      vis_we    = 1'b1;
      vis_waddr = '0;
    end else if (carve) begin
      vis_we = 1'b1;
    end
    vis_re    = (state == ST_PROBE) && inb;
    vis_raddr = {ny, nx};
  end

  dmc_ram #(.AW(SAW), .DW(VW)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (count_m1[SAW-1:0]),
    .rdata (stk_rdata)
  );

  dmc_ram #(.AW(VW), .DW(1)) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .re    (vis_re),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      report    <= 1'b0;
      count     <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && (!out_valid || res.ready)) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + VW'(1);
          if (clr_addr == '1) begin
            state <= ST_SEED;
          end
        end
        ST_SEED: begin
          count  <= CNTW'(1);
          rslt   <= make_result(dmc_pkg::EV_RESTART, '0, '0, dmc_pkg::DIR_UP, CNTW'(1));
          report <= 1'b0;
          state  <= report ? ST_EMIT : ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            if (req.req_type == dmc_pkg::REQ_RESTART) begin
              report   <= 1'b1;
              clr_addr <= '0;
              state    <= ST_CLEAR;
            end else if (count == '0) begin
              rslt  <= make_result(dmc_pkg::EV_IDLE, '0, '0, dmc_pkg::DIR_UP, '0);
              state <= ST_EMIT;
            end else begin
              order <= dmc_pkg::shuffle_order(req.draw_three, req.draw_two, req.draw_one);
              k     <= '0;
              state <= ST_TOP;
            end
          end
        end
        ST_TOP: begin
          cur_x <= stk_rdata[XW-1:0];
          cur_y <= stk_rdata[VW-1:XW];
          state <= ST_PROBE;
        end
        ST_PROBE: begin
          cand_x   <= nx;
          cand_y   <= ny;
          cand_dir <= pd;
          if (inb) begin
            state <= ST_CHECK;
          end else if (k == 2'd3) begin
            state <= ST_POP;
          end else begin
            k <= k + 2'd1;
          end
        end
        ST_CHECK: begin
          if (!vis_rdata[0]) begin
            if (count < CELLS_CNT) begin
              count <= count + CNTW'(1);
              rslt  <= make_result(dmc_pkg::EV_CARVE, cand_x, cand_y, cand_dir,
                                   count + CNTW'(1));
            end else begin
              rslt  <= make_result(dmc_pkg::EV_CARVE, cand_x, cand_y, cand_dir, count);
            end
            state <= ST_EMIT;
          end else if (k == 2'd3) begin
            state <= ST_POP;
          end else begin
            k     <= k + 2'd1;
            state <= ST_PROBE;
          end
        end
        ST_POP: begin
          count <= count_m1;
          rslt  <= make_result(dmc_pkg::EV_BACKTRACK, cur_x, cur_y, dmc_pkg::DIR_UP, count_m1);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // hold until the result register is free
          if (!out_valid || res.ready) begin
            out_data <= rslt;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign res.valid       = out_valid;
  assign res.event_res   = out_data.event_res;
  assign res.cell_x      = out_data.cell_x;
  assign res.cell_y      = out_data.cell_y;
  assign res.direction   = out_data.direction;
  assign res.stack_depth = out_data.stack_depth;
  assign res.maze_done   = out_data.maze_done;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CELLS_CNT)
    else $error("stack count beyond grid size");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    carve |-> (count < CELLS_CNT))
    else $error("push onto a full stack");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> (count != '0))
    else $error("pop from an empty stack");

  a_vis_no_collide: assert property (@(posedge clk) disable iff (rst)
    (vis_we && vis_re) |-> (vis_waddr != vis_raddr))
    else $error("visited map read and write hit the same entry");

  a_top_read: assert property (@(posedge clk) disable iff (rst)
    stk_re |=> (state == ST_TOP))
    else $error("stack read without a top capture");

endmodule

// File: tb/dfs_maze_carver_test.sv
// Self-checking bench for dfs_maze_carver: random requests on the request channel and
// random stalls on the result channel, results checked against an in-bench maze
// predictor. Depends on dmc_pkg, dmc_ifs and dfs_maze_carver.
`timescale 1ns / 100ps

module dfs_maze_carver_test;

  localparam int COLS = dmc_pkg::GRID_COLS_DEF;
  localparam int ROWS = dmc_pkg::GRID_ROWS_DEF;
  localparam int CELLS = COLS * ROWS;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst;

  dmc_req_if req_ch ();
  dmc_res_if res_ch ();

  dfs_maze_carver DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // predictor state
  logic [CELLS-1:0] seen_cells;
  logic [7:0]       path_stack [CELLS];
  int               path_depth;
  dmc_pkg::result_t maze_events_q [$];

  int  mismatch_count;
  int  carve_count;
  int  backtrack_count;
  int  idle_count;
  int  restart_count;
  int  result_count;
  int  quiet_cycles;
  bit  steady;
  int  stall_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void clear_maze();
    seen_cells    = '0;
    seen_cells[0] = 1'b1;
    path_stack[0] = 8'd0;
    path_depth    = 1;
  endfunction

  // Work out one result and advance the maze state.
  function automatic dmc_pkg::result_t maze_step(input logic kind, input logic [1:0] d3,
                                                 input logic [1:0] d2, input logic d1);
    dmc_pkg::result_t r;
    logic [1:0] ord [4];
    logic [1:0] tmp;
    logic [1:0] p2;
    logic [7:0] top;
    int         cx, cy, nx, ny, k, idx;
    bit         found;
    r = '0;
    if (kind == dmc_pkg::REQ_RESTART) begin
      clear_maze();
      r.event_res = dmc_pkg::EV_RESTART;
      restart_count++;
    end else if (path_depth == 0) begin
      r.event_res = dmc_pkg::EV_IDLE;
      idle_count++;
    end else begin
      ord = '{dmc_pkg::DIR_UP, dmc_pkg::DIR_RIGHT, dmc_pkg::DIR_DOWN, dmc_pkg::DIR_LEFT};
      tmp = ord[3]; ord[3] = ord[d3]; ord[d3] = tmp;
      p2 = (d2 == 2'd3) ? 2'd0 : d2;
      tmp = ord[2]; ord[2] = ord[p2]; ord[p2] = tmp;
      tmp = ord[1]; ord[1] = ord[d1]; ord[d1] = tmp;
      top = path_stack[path_depth - 1];
      cx = top % COLS;
      cy = top / COLS;
      found = 1'b0;
      for (k = 0; k < 4 && !found; k++) begin
        nx = cx;
        ny = cy;
        case (ord[k])
          dmc_pkg::DIR_UP:    ny = cy - 1;
          dmc_pkg::DIR_RIGHT: nx = cx + 1;
          dmc_pkg::DIR_DOWN:  ny = cy + 1;
          default:            nx = cx - 1;
        endcase
        if (nx >= 0 && nx < COLS && ny >= 0 && ny < ROWS && !seen_cells[ny * COLS + nx]) begin
          found = 1'b1;
          idx = ny * COLS + nx;
          seen_cells[idx] = 1'b1;
          path_stack[path_depth] = 8'(idx);
          path_depth++;
          r.event_res = dmc_pkg::EV_CARVE;
          r.cell_x    = 4'(nx);
          r.cell_y    = 4'(ny);
          r.direction = ord[k];
          carve_count++;
        end
      end
      if (!found) begin
        path_depth--;
        r.event_res = dmc_pkg::EV_BACKTRACK;
        r.cell_x    = 4'(cx);
        r.cell_y    = 4'(cy);
        backtrack_count++;
      end
    end
    r.stack_depth = 9'(path_depth);
    r.maze_done   = (path_depth == 0);
    return r;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Hold the request until accepted, then predict its result.
  task automatic send_request(input logic kind, input logic [1:0] d3,
                              input logic [1:0] d2, input logic d1);
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.draw_three <= d3;
    req_ch.draw_two   <= d2;
    req_ch.draw_one   <= d1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    maze_events_q.push_back(maze_step(kind, d3, d2, d1));
  endtask

  task automatic pause_sender();
    int n;
    n = steady ? 0 : pick_gap();
    if (n > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_random_step();
    send_request(dmc_pkg::REQ_STEP, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)));
    pause_sender();
  endtask

  // Draw extremes from the reset state, then across restarts.
  task automatic test_directed();
    steady = 1'b1;
    send_request(dmc_pkg::REQ_STEP, 2'd0, 2'd0, 1'b0);
    send_request(dmc_pkg::REQ_STEP, 2'd3, 2'd3, 1'b1);
    send_request(dmc_pkg::REQ_STEP, 2'd3, 2'd2, 1'b0);
    send_request(dmc_pkg::REQ_STEP, 2'd1, 2'd3, 1'b1);
    send_request(dmc_pkg::REQ_STEP, 2'd2, 2'd1, 1'b0);
    send_request(dmc_pkg::REQ_STEP, 2'd0, 2'd2, 1'b1);
    send_request(dmc_pkg::REQ_RESTART, 2'd3, 2'd3, 1'b1);
    send_request(dmc_pkg::REQ_STEP, 2'd3, 2'd0, 1'b1);
    send_request(dmc_pkg::REQ_STEP, 2'd2, 2'd3, 1'b0);
    send_request(dmc_pkg::REQ_STEP, 2'd1, 2'd1, 1'b1);
    send_request(dmc_pkg::REQ_STEP, 2'd0, 2'd0, 1'b0);
    send_request(dmc_pkg::REQ_STEP, 2'd3, 2'd2, 1'b1);
    send_request(dmc_pkg::REQ_RESTART, 2'd0, 2'd0, 1'b0);
    send_request(dmc_pkg::REQ_RESTART, 2'd2, 2'd1, 1'b0);
    send_request(dmc_pkg::REQ_STEP, 2'd1, 2'd2, 1'b0);
    send_request(dmc_pkg::REQ_STEP, 2'd0, 2'd3, 1'b0);
    send_request(dmc_pkg::REQ_STEP, 2'd2, 2'd0, 1'b1);
    steady = 1'b0;
  endtask

  // From a restart, carve the whole grid, backtrack to an empty stack, step on it, then restart.
  task automatic test_full_walk();
    send_request(dmc_pkg::REQ_RESTART, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)));
    pause_sender();
    while (path_depth != 0) send_random_step();
    repeat (3) send_random_step();
    send_request(dmc_pkg::REQ_RESTART, 2'd0, 2'd0, 1'b0);
    pause_sender();
  endtask

  // Mostly steps with random draws; the odd restart breaks a walk midway.
  task automatic test_random_mix();
    int i;
    for (i = 0; i < 480; i++) begin
      if (i % 80 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 3) begin
        send_request(dmc_pkg::REQ_RESTART, 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        pause_sender();
      end else begin
        send_random_step();
      end
    end
    steady = 1'b0;
  endtask

  task automatic finish_run();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (maze_events_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d carves, %0d backtracks, %0d idle steps, %0d restarts.",
             result_count, carve_count, backtrack_count, idle_count, restart_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  endtask

  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = dmc_pkg::REQ_STEP;
    req_ch.draw_three = 2'd0;
    req_ch.draw_two   = 2'd0;
    req_ch.draw_one   = 1'b0;
    mismatch_count    = 0;
    carve_count       = 0;
    backtrack_count   = 0;
    idle_count        = 0;
    restart_count     = 0;
    result_count      = 0;
    steady            = 1'b0;
    clear_maze();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_walk();
    test_random_mix();
    finish_run();
  end

  // result side stalls
  initial begin
    res_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        if (!steady) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    dmc_pkg::result_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      result_count++;
      if (maze_events_q.size() == 0) begin
        report_mismatch("unrequested result, event_res", res_ch.event_res, -1);
      end else begin
        want = maze_events_q.pop_front();
        check_field("event_res", res_ch.event_res, want.event_res);
        check_field("cell_x", res_ch.cell_x, want.cell_x);
        check_field("cell_y", res_ch.cell_y, want.cell_y);
        check_field("direction", res_ch.direction, want.direction);
        check_field("stack_depth", res_ch.stack_depth, want.stack_depth);
        check_field("maze_done", res_ch.maze_done, want.maze_done);
      end
    end
  end

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d cycles without a transfer", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial quiet_cycles = 0;

endmodule
